// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, quiet during reset.
`define BLR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, quiet during reset.
`define BLR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BLR_ASSERT_IMPL(lbl, ante, cons, msg)
`define BLR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/blr_pkg.sv =====
// ----------------------------------------------------------------------------
// blr_pkg
// Types and codes shared by the line rasterizer modules.
// ----------------------------------------------------------------------------
package blr_pkg;

	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_ADVANCE = 1'b1;

	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// Per-line setup produced from a load word.
	typedef struct packed {
		logic               steep;
		logic signed [16:0] major_pos;
		logic signed [16:0] major_end;
		logic signed [16:0] minor_pos;
		logic               minor_dir;   // 1 = minor coordinate decreases
		logic        [16:0] delta_major;
		logic        [16:0] delta_minor;
		logic signed [17:0] error_acc;
	} line_t;

	// Clipped and rotated pixel position.
	typedef struct packed {
		logic [9:0] panel_x;
		logic [9:0] panel_y;
		logic       visible;
	} pix_t;

endpackage

// ===== rtl/blr_setup.sv =====
// ----------------------------------------------------------------------------
// blr_setup
// Turns two logical endpoints into Bresenham state ordered along the major axis.
// ----------------------------------------------------------------------------
module blr_setup (
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	output blr_pkg::line_t     line
);
	import blr_pkg::*;

	logic signed [16:0] x0, y0, x1, y1, dx, dy, dn;
	logic signed [16:0] a0, a1, b0, b1, m0, m1, n0, n1;
	logic        [16:0] adx, ady, dmaj;
	logic               steep, swap;

	always_comb begin
		x0 = 17'(start_x);
		y0 = 17'(start_y);
		x1 = 17'(end_x);
		y1 = 17'(end_y);
		dx = x1 - x0;
		dy = y1 - y0;
		adx = dx[16] ? 17'(-dx) : 17'(dx);
		ady = dy[16] ? 17'(-dy) : 17'(dy);
		steep = ady > adx;

		// Put the faster-changing axis first.
		a0 = steep ? y0 : x0;
		b0 = steep ? x0 : y0;
		a1 = steep ? y1 : x1;
		b1 = steep ? x1 : y1;

		// Walk the major axis upward.
		swap = a0 > a1;
		m0 = swap ? a1 : a0;
		m1 = swap ? a0 : a1;
		n0 = swap ? b1 : b0;
		n1 = swap ? b0 : b1;

		dmaj = 17'(m1 - m0);
		dn   = n1 - n0;

		line.steep       = steep;
		line.major_pos   = m0;
		line.major_end   = m1;
		line.minor_pos   = n0;
		line.minor_dir   = !(n0 < n1);
		line.delta_major = dmaj;
		line.delta_minor = dn[16] ? 17'(-dn) : 17'(dn);
		line.error_acc   = $signed({2'b00, dmaj[16:1]});
	end

endmodule

// ===== rtl/blr_pixel.sv =====
// ----------------------------------------------------------------------------
// blr_pixel
// Clips a logical pixel to the rotated screen and maps it to panel coordinates.
// ----------------------------------------------------------------------------
module blr_pixel #(
	parameter int PANEL_WIDTH  = 800,
	parameter int PANEL_HEIGHT = 600
) (
	input  logic signed [16:0] lx,
	input  logic signed [16:0] ly,
	input  logic        [1:0]  rotation,
	output blr_pkg::pix_t      pix
);
	import blr_pkg::*;

	localparam logic [16:0] PW     = 17'(PANEL_WIDTH);
	localparam logic [16:0] PH     = 17'(PANEL_HEIGHT);
	localparam logic [9:0]  PW_MAX = 10'(PANEL_WIDTH - 1);
	localparam logic [9:0]  PH_MAX = 10'(PANEL_HEIGHT - 1);

	logic [16:0] lw, lh;
	logic        vis;

	always_comb begin
		// Odd quarter turns swap the logical width and height.
		lw  = rotation[0] ? PH : PW;
		lh  = rotation[0] ? PW : PH;
		vis = !lx[16] && !ly[16] && (lx < lw) && (ly < lh);

		pix.visible = vis;
		pix.panel_x = '0;
		pix.panel_y = '0;
		if (vis) begin
			case (rotation)
				ROT_0: begin
					pix.panel_x = lx[9:0];
					pix.panel_y = ly[9:0];
				end
				ROT_90: begin
					pix.panel_x = PW_MAX - ly[9:0];
					pix.panel_y = lx[9:0];
				end
				ROT_180: begin
					pix.panel_x = PW_MAX - lx[9:0];
					pix.panel_y = PH_MAX - ly[9:0];
				end
				ROT_270: begin
					pix.panel_x = ly[9:0];
					pix.panel_y = PH_MAX - lx[9:0];
				end
				default: begin
					pix.panel_x = '0;
					pix.panel_y = '0;
				end
			endcase
		end
	end

endmodule

// ===== rtl/bresenham_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Bresenham line walker with clipping and panel rotation, one pixel per clock unless the output stalls.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                     Direction
//   -------   -----------------------------------------   ---------
//   input     in_valid/in_ready, func, endpoints, ink      in
//   output    out_valid/out_ready, panel_x/y, pixel_ink,   out
//             visible, last
//   config    cfg_wr_en, cfg_wr_data (rotation)            in
//
// A word taken at a clock edge sits in the input register while the setup
// or step logic works on it, and its pixel is then loaded into the result
// register when the step stage moves. A new word is taken every clock while
// the output is not stalled; throughput is bounded by the subtract and
// add-back of the error step that feeds the line state registers.
// Reset clears the line state, so advance words are dropped until a load.
// A stalled output holds the input register; ready falls only then.
//
`include "assert_macros.svh"

module bresenham_line_rasterizer #(
	parameter int PANEL_WIDTH  = 800,
	parameter int PANEL_HEIGHT = 600
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_wr_data,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	input  logic [15:0]        ink,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [9:0]         panel_x,
	output logic [9:0]         panel_y,
	output logic [15:0]        pixel_ink,
	output logic               visible,
	output logic               last
);
	import blr_pkg::*;

	// Panel size at a width that holds the full parameter range.
	localparam logic [10:0] PW_LIM = 11'(PANEL_WIDTH);
	localparam logic [10:0] PH_LIM = 11'(PANEL_HEIGHT);

	// Rotation register, applied to each pixel as it is emitted.
	logic [1:0] rotation_q;

	// Input register.
	logic               valid_s1;
	logic               func_s1;
	logic signed [15:0] start_x_s1, start_y_s1, end_x_s1, end_y_s1;
	logic [15:0]        ink_s1;

	// Line state.
	logic               active_q;
	line_t              line_q;
	logic [15:0]        ink_q;

	// Result register.
	logic               out_valid_q;
	pix_t               pix_q;
	logic [15:0]        pixel_ink_q;
	logic               last_q;

	line_t              setup;
	pix_t               pix;
	logic               proceed, fire, emit, fin, err_neg;
	logic signed [17:0] err_sub;
	logic signed [16:0] lx, ly;

	// The step stage moves whenever the result register is free or draining.
	assign proceed  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || proceed;
	assign fire     = valid_s1 && proceed;
	assign emit     = fire && (func_s1 == FUNC_ADVANCE) && active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= ROT_0;
		end else if (cfg_wr_en) begin
			rotation_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1    <= func;
			start_x_s1 <= start_x;
			start_y_s1 <= start_y;
			end_x_s1   <= end_x;
			end_y_s1   <= end_y;
			ink_s1     <= ink;
		end
	end

	blr_setup u_setup (
		.start_x (start_x_s1),
		.start_y (start_y_s1),
		.end_x   (end_x_s1),
		.end_y   (end_y_s1),
		.line    (setup)
	);

	// The current pixel in logical coordinates, before the step.
	assign lx  = line_q.steep ? line_q.minor_pos : line_q.major_pos;
	assign ly  = line_q.steep ? line_q.major_pos : line_q.minor_pos;
	assign fin = line_q.major_pos >= line_q.major_end;

	blr_pixel #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_pixel (
		.lx       (lx),
		.ly       (ly),
		.rotation (rotation_q),
		.pix      (pix)
	);

	// Error step: subtract the minor delta, and on a borrow move the minor
	// coordinate one unit and add back the major delta.
	assign err_sub = line_q.error_acc - $signed({1'b0, line_q.delta_minor});
	assign err_neg = err_sub[17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			line_q   <= '0;
			ink_q    <= '0;
		end else if (fire) begin
			if (func_s1 == FUNC_LOAD) begin
				// A load replaces any line still in progress.
				active_q <= 1'b1;
				line_q   <= setup;
				ink_q    <= ink_s1;
			end else if (active_q) begin
				if (fin) begin
					active_q <= 1'b0;
				end else begin
					line_q.major_pos <= line_q.major_pos + 17'sd1;
					if (err_neg) begin
						line_q.error_acc <= err_sub + $signed({1'b0, line_q.delta_major});
						line_q.minor_pos <= line_q.minor_dir ? line_q.minor_pos - 17'sd1
							: line_q.minor_pos + 17'sd1;
					end else begin
						line_q.error_acc <= err_sub;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proceed) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pix_q       <= pix;
			pixel_ink_q <= ink_q;
			last_q      <= fin;
		end
	end

	assign out_valid = out_valid_q;
	assign panel_x   = pix_q.panel_x;
	assign panel_y   = pix_q.panel_y;
	assign pixel_ink = pixel_ink_q;
	assign visible   = pix_q.visible;
	assign last      = last_q;

	`BLR_ASSERT_IMPL(a_clip_zero, out_valid_q && !pix_q.visible, pix_q.panel_x == 10'd0 && pix_q.panel_y == 10'd0, "clipped pixel carries nonzero coordinates")
	`BLR_ASSERT_IMPL(a_on_panel, out_valid_q && pix_q.visible, pix_q.panel_x < PW_LIM && pix_q.panel_y < PH_LIM, "visible pixel lies off the panel")
	`BLR_ASSERT_NEXT(a_last_ends, emit && fin, !active_q, "line still active after its last pixel")
	`BLR_ASSERT_NEXT(a_load_starts, fire && func_s1 == FUNC_LOAD, active_q && !out_valid_q, "load did not start a line or produced a pixel")

endmodule

// ===== tb/blr_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// blr_pixel_checker
// Watches the input, output and rotation ports of the line rasterizer, keeps
// its own line state, predicts each pixel word and compares it field by field.
// ----------------------------------------------------------------------------
module blr_pixel_checker #(
	parameter int PANEL_WIDTH  = 800,
	parameter int PANEL_HEIGHT = 600
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_wr_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               func,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	input  logic [15:0]        ink,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [9:0]         panel_x,
	input  logic [9:0]         panel_y,
	input  logic [15:0]        pixel_ink,
	input  logic               visible,
	input  logic               last,
	output int                 mismatch_count,
	output int                 pending_pixels
);
	timeunit 1ns;
	timeprecision 1ps;
	import blr_pkg::*;

	typedef struct packed {
		logic [9:0]  px;
		logic [9:0]  py;
		logic [15:0] ink;
		logic        vis;
		logic        fin;
	} pixel_t;

	pixel_t pixel_q[$];
	pixel_t want;

	// Line state of the walker as the design should hold it.
	logic [1:0]         rot_reg;
	logic               ln_active;
	logic               ln_steep;
	logic signed [16:0] ln_major;
	logic signed [16:0] ln_major_end;
	logic signed [16:0] ln_minor;
	logic               ln_minor_down;
	logic [16:0]        ln_dmajor;
	logic [16:0]        ln_dminor;
	logic signed [17:0] ln_err;
	logic [15:0]        ln_ink;

	function automatic logic signed [17:0] mag18(input logic signed [17:0] v);
		return (v < 0) ? -v : v;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t ns: pixel check: %s", $time, msg);
	endtask

	// Applies one accepted word to the line state and queues the pixel it emits.
	task automatic rasterize_word(input logic f, input logic signed [15:0] sx,
			input logic signed [15:0] sy, input logic signed [15:0] ex,
			input logic signed [15:0] ey, input logic [15:0] k);
		logic signed [16:0] x0, y0, x1, y1, tmp, lx, ly;
		logic signed [17:0] span;
		int     lw, lh, px, py;
		pixel_t p;
		if (f == FUNC_LOAD) begin
			x0 = sx;
			y0 = sy;
			x1 = ex;
			y1 = ey;
			ln_steep = mag18(y1 - y0) > mag18(x1 - x0);
			if (ln_steep) begin
				tmp = x0; x0 = y0; y0 = tmp;
				tmp = x1; x1 = y1; y1 = tmp;
			end
			if (x0 > x1) begin
				tmp = x0; x0 = x1; x1 = tmp;
				tmp = y0; y0 = y1; y1 = tmp;
			end
			ln_major      = x0;
			ln_major_end  = x1;
			ln_minor      = y0;
			ln_minor_down = !(y0 < y1);
			span          = x1 - x0;
			ln_dmajor     = span[16:0];
			span          = mag18(y1 - y0);
			ln_dminor     = span[16:0];
			ln_err        = $signed({1'b0, ln_dmajor >> 1});
			ln_ink        = k;
			ln_active     = 1'b1;
		end else if (ln_active) begin
			lx = ln_steep ? ln_minor : ln_major;
			ly = ln_steep ? ln_major : ln_minor;
			lw = rot_reg[0] ? PANEL_HEIGHT : PANEL_WIDTH;
			lh = rot_reg[0] ? PANEL_WIDTH : PANEL_HEIGHT;
			p.vis = (lx >= 0) && (ly >= 0) && (lx < lw) && (ly < lh);
			p.fin = ln_major >= ln_major_end;
			p.ink = ln_ink;
			px = 0;
			py = 0;
			if (p.vis) begin
				case (rot_reg)
					ROT_0: begin
						px = lx;
						py = ly;
					end
					ROT_90: begin
						px = PANEL_WIDTH - 1 - ly;
						py = lx;
					end
					ROT_180: begin
						px = PANEL_WIDTH - 1 - lx;
						py = PANEL_HEIGHT - 1 - ly;
					end
					default: begin
						px = ly;
						py = PANEL_HEIGHT - 1 - lx;
					end
				endcase
			end
			p.px = px[9:0];
			p.py = py[9:0];
			pixel_q.push_back(p);
			if (p.fin) begin
				ln_active = 1'b0;
			end else begin
				ln_err = ln_err - $signed({1'b0, ln_dminor});
				if (ln_err < 0) begin
					ln_minor = ln_minor_down ? ln_minor - 17'sd1 : ln_minor + 17'sd1;
					ln_err   = ln_err + $signed({1'b0, ln_dmajor});
				end
				ln_major = ln_major + 17'sd1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_q.delete();
			rot_reg       = ROT_0;
			ln_active     = 1'b0;
			ln_steep      = 1'b0;
			ln_major      = '0;
			ln_major_end  = '0;
			ln_minor      = '0;
			ln_minor_down = 1'b0;
			ln_dmajor     = '0;
			ln_dminor     = '0;
			ln_err        = '0;
			ln_ink        = '0;
		end else begin
			if (in_valid && in_ready)
				rasterize_word(func, start_x, start_y, end_x, end_y, ink);
			if (out_valid && out_ready) begin
				if (pixel_q.size() == 0) begin
					report_mismatch($sformatf("pixel word (%0d,%0d) with none expected",
						panel_x, panel_y));
				end else begin
					want = pixel_q.pop_front();
					if (panel_x !== want.px)
						report_mismatch($sformatf("panel_x %0d, expected %0d", panel_x, want.px));
					if (panel_y !== want.py)
						report_mismatch($sformatf("panel_y %0d, expected %0d", panel_y, want.py));
					if (pixel_ink !== want.ink)
						report_mismatch($sformatf("pixel_ink %h, expected %h", pixel_ink, want.ink));
					if (visible !== want.vis)
						report_mismatch($sformatf("visible %b, expected %b", visible, want.vis));
					if (last !== want.fin)
						report_mismatch($sformatf("last %b, expected %b", last, want.fin));
				end
			end
			if (cfg_wr_en)
				rot_reg = cfg_wr_data;
		end
		pending_pixels = pixel_q.size();
	end

endmodule

// ===== tb/bresenham_line_rasterizer_tb.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_tb
// Drives load and advance words into the line rasterizer under all four
// rotations and lets a checker compare every pixel word it emits.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import blr_pkg::*;

	localparam int PANEL_W         = 800;
	localparam int PANEL_H         = 600;
	// Two register stages sit between an advance word and its pixel, so a
	// handful of clocks is plenty to let the pipe drain.
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int RANDOM_WORDS    = 1750;
	localparam int PHASES          = 5;
	localparam int CYCLE_LIMIT     = 500000;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [1:0]         cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	logic               func;
	logic signed [15:0] start_x;
	logic signed [15:0] start_y;
	logic signed [15:0] end_x;
	logic signed [15:0] end_y;
	logic [15:0]        ink;
	logic               out_valid;
	logic               out_ready;
	logic [9:0]         panel_x;
	logic [9:0]         panel_y;
	logic [15:0]        pixel_ink;
	logic               visible;
	logic               last;

	int mismatch_count;
	int pending_pixels;
	int cycle_count;
	int burst_left;
	// The stimulus raises hold_req once; the receiver then parks out_ready
	// low for a long stretch and flags hold_done when it lets go.
	bit hold_req;
	bit hold_done;

	bresenham_line_rasterizer #(
		.PANEL_WIDTH (PANEL_W),
		.PANEL_HEIGHT(PANEL_H)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.ink        (ink),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.panel_x    (panel_x),
		.panel_y    (panel_y),
		.pixel_ink  (pixel_ink),
		.visible    (visible),
		.last       (last)
	);

	blr_pixel_checker #(
		.PANEL_WIDTH (PANEL_W),
		.PANEL_HEIGHT(PANEL_H)
	) pixel_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.ink           (ink),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.panel_x       (panel_x),
		.panel_y       (panel_y),
		.pixel_ink     (pixel_ink),
		.visible       (visible),
		.last          (last),
		.mismatch_count(mismatch_count),
		.pending_pixels(pending_pixels)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bresenham_line_rasterizer: mismatch");
			$finish;
		end
	end

	// Receiver. It changes out_ready on falling edges and switches between a
	// few stall patterns: always ready, coin flip, mostly stalled and a
	// strict toggle. Each pattern holds for a random stretch so that stalls
	// land on every phase of the line walk.
	initial begin
		int mode;
		int span;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				if (hold_req && !hold_done) begin
					// Long hold-off: the sender keeps offering words, so the
					// pipe fills and in_ready has to drop.
					out_ready <= 1'b0;
					repeat (HOLD_OFF_CYCLES) @(negedge clk);
					hold_done = 1'b1;
				end
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= 1'($urandom_range(0, 1));
					2:       out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ~out_ready;
				endcase
			end
		end
	end

	// Offers one word and returns at the rising edge that takes it. The
	// sender runs in bursts; when a burst is used up valid drops for a random
	// gap first. Long bursts give stretches with no idling at all.
	task automatic send_word(input logic f, input logic signed [15:0] sx,
			input logic signed [15:0] sy, input logic signed [15:0] ex,
			input logic signed [15:0] ey, input logic [15:0] k);
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		func     <= f;
		start_x  <= sx;
		start_y  <= sy;
		end_x    <= ex;
		end_y    <= ey;
		ink      <= k;
		do @(posedge clk); while (!in_ready);
	endtask

	// Advance words carry random payloads; the block must ignore them.
	task automatic send_advance();
		send_word(FUNC_ADVANCE, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	// Drops valid and waits until every predicted pixel has come out.
	task automatic wait_for_pixels();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels != 0) @(negedge clk);
	endtask

	// The rotation is only changed with the block idle. An advance word on an
	// idle walker leaves no pixel to wait for, so a few clocks more are given
	// for the pipe to empty before the write.
	task automatic write_rotation(input logic [1:0] r);
		wait_for_pixels();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= r;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Random traffic. Most of it is well formed: a load followed by enough
	// advances to walk the whole line. The rest cuts lines short so that the
	// next load replaces them, walks past the end, uses full-range endpoints,
	// or sends stray advances.
	task automatic random_lines(input int budget);
		int kind;
		int x0, y0, dx, dy, len, steps, extra, reach;
		while (budget > 0) begin
			kind  = $urandom_range(0, 99);
			extra = 0;
			if (kind < 85) begin
				x0 = int'($urandom_range(0, 920)) - 60;
				y0 = int'($urandom_range(0, 920)) - 60;
				if (kind < 70) begin
					reach = (kind < 60) ? 40 : 150;
					dx = int'($urandom_range(0, 2 * reach)) - reach;
					dy = int'($urandom_range(0, 2 * reach)) - reach;
				end else begin
					// Single-point line.
					dx = 0;
					dy = 0;
				end
				len   = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
				                                                   : (dy < 0 ? -dy : dy);
				steps = len + 1;
				case ($urandom_range(0, 19))
					0, 1, 2: steps = $urandom_range(1, len + 1);
					3, 4:    extra = $urandom_range(1, 2);
					default: ;
				endcase
				send_word(FUNC_LOAD, 16'(x0), 16'(y0), 16'(x0 + dx), 16'(y0 + dy),
					16'($urandom));
			end else if (kind < 93) begin
				// Full-range endpoints; only the first few pixels are walked.
				steps = $urandom_range(1, 6);
				send_word(FUNC_LOAD, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
			end else begin
				// Stray advances: they continue a cut line or hit an idle walker.
				steps = 0;
				extra = $urandom_range(1, 3);
			end
			budget -= (steps == 0) ? 0 : steps + 1;
			repeat (steps + extra) send_advance();
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = ROT_0;
		in_valid    = 1'b0;
		func        = FUNC_LOAD;
		start_x     = '0;
		start_y     = '0;
		end_x       = '0;
		end_y       = '0;
		ink         = '0;
		burst_left  = 0;
		hold_req    = 1'b0;
		hold_done   = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed words, with the rotation still at its reset value.
		// An advance right after reset finds no line and must stay silent.
		send_advance();
		// Longest possible line, corner to corner; the first pixels are
		// clipped far off screen.
		send_word(FUNC_LOAD, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'hFFFF);
		repeat (2) send_advance();
		// A load in the middle of a line replaces it; the endpoints come in
		// reversed along the major axis.
		send_word(FUNC_LOAD, 16'sd32767, 16'sd0, -16'sd32768, 16'sd5, 16'h0000);
		repeat (2) send_advance();
		// Single-point line in the bottom right corner: one pixel, marked last,
		// and then the walker is idle again.
		send_word(FUNC_LOAD, 16'sd799, 16'sd599, 16'sd799, 16'sd599, 16'h8001);
		repeat (2) send_advance();
		// Steep line given bottom to top, so the minor coordinate falls.
		send_word(FUNC_LOAD, 16'sd2, 16'sd10, 16'sd5, 16'sd0, 16'h5A5A);
		repeat (11) send_advance();

		// Random phases, one rotation each; the last one picks at random.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       write_rotation(ROT_270);
				1:       write_rotation(ROT_90);
				2:       write_rotation(ROT_180);
				3:       write_rotation(ROT_0);
				default: write_rotation(2'($urandom_range(0, 3)));
			endcase
			if (p == 1)
				hold_req = 1'b1;
			random_lines(RANDOM_WORDS / (2 * PHASES));
			// Once, the sender pauses until the output side has caught up.
			if (p == 2)
				wait_for_pixels();
			random_lines(RANDOM_WORDS / (2 * PHASES));
		end

		wait_for_pixels();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && pending_pixels == 0)
			$display("bresenham_line_rasterizer: match");
		else
			$display("bresenham_line_rasterizer: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/blr_pkg.sv
rtl/blr_setup.sv
rtl/blr_pixel.sv
rtl/bresenham_line_rasterizer.sv
tb/blr_pixel_checker.sv
tb/bresenham_line_rasterizer_tb.sv
